@@ rtl/mrsd_pkg.sv @@
// Shared types and constants of the macro record stream decoder.
// No dependencies; every other file of the block refers to this package.
package mrsd_pkg;

    // Stream limit: bytes past this count are ignored.
    localparam int unsigned MAX_STREAM_BYTES = 1024;
    localparam int unsigned POS_W            = $clog2(MAX_STREAM_BYTES + 1);

    localparam logic [POS_W-1:0] POS_LIMIT      = POS_W'(MAX_STREAM_BYTES);
    localparam logic [POS_W-1:0] POS_PROBE_LAST = POS_W'(7);
    localparam logic [POS_W-1:0] POS_PROBE_LEN  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_COUNT_HI   = POS_W'(32);
    localparam logic [POS_W-1:0] POS_COUNT_LO   = POS_W'(33);
    localparam logic [POS_W-1:0] POS_MODE       = POS_W'(34);
    localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(35);

    // Leading bytes of a record kept for decoding.
    localparam int unsigned REC_KEEP  = 9;
    localparam int unsigned REC_IDX_W = $clog2(REC_KEEP);

    localparam logic [7:0] REC_TYPE_KEY   = 8'd1;
    localparam logic [7:0] REC_TYPE_MOUSE = 8'd2;
    localparam logic [7:0] KEY_MIN_LEN    = 8'd7;
    localparam logic [7:0] MOUSE_MIN_LEN  = 8'd9;

    // Depth of the queue between the front and back parts.
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Result kinds.
    localparam logic [3:0] KIND_HEADER    = 4'd0;
    localparam logic [3:0] KIND_KEY       = 4'd1;
    localparam logic [3:0] KIND_MOUSE     = 4'd2;
    localparam logic [3:0] KIND_UNKNOWN   = 4'd3;
    localparam logic [3:0] KIND_TRUNCATED = 4'd4;
    localparam logic [3:0] KIND_EMPTY     = 4'd5;
    localparam logic [3:0] KIND_NO_DATA   = 4'd6;
    localparam logic [3:0] KIND_SHORT_HDR = 4'd7;
    localparam logic [3:0] KIND_END       = 4'd8;

    typedef logic [REC_KEEP-1:0][7:0] t_rec_buf;

    typedef struct packed {
        logic [3:0]         result_kind;
        logic [9:0]         step_number;
        logic [15:0]        count_value;
        logic [7:0]         mode_or_kind;
        logic [7:0]         modifier_mask;
        logic [7:0]         key_code;
        logic [7:0]         action_type;
        logic [15:0]        delay_ms;
        logic [7:0]         button_mask;
        logic signed [7:0]  move_x;
        logic signed [7:0]  move_y;
        logic [7:0]         wheel_value;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

@@ rtl/mrsd_front.sv @@
// Front part: accepts stream bytes, tracks slot state and builds result transactions.
// Depends on mrsd_pkg.
module mrsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_stream,
    input  mrsd_pkg::t_fifo_status i_fifo_status,
    output logic                o_push,
    output mrsd_pkg::t_result   o_push_data
);

    logic [mrsd_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_zero, n_zero;
    logic                       r_ones, n_ones;
    logic [15:0]                r_hdr, n_hdr;
    logic [7:0]                 r_len, n_len;
    logic [7:0]                 r_off, n_off;
    mrsd_pkg::t_rec_buf         r_buf, n_buf;
    logic [9:0]                 r_cnt, n_cnt;
    logic                       r_stop, n_stop;
    logic                       accept;
    logic                       has_res;
    mrsd_pkg::t_result          res;

    // Decode a completed record from its kept bytes.
    function automatic mrsd_pkg::t_result decode_record(
        input mrsd_pkg::t_rec_buf a,
        input logic [7:0]         len,
        input logic [9:0]         cnt
    );
        mrsd_pkg::t_result r;
        r             = '0;
        r.step_number = cnt + 10'd1;
        r.count_value = {8'd0, len};
        if (len >= mrsd_pkg::KEY_MIN_LEN && a[1] == mrsd_pkg::REC_TYPE_KEY) begin
            r.result_kind   = mrsd_pkg::KIND_KEY;
            r.modifier_mask = a[2];
            r.key_code      = a[3];
            r.action_type   = a[4];
            r.delay_ms      = {a[5], a[6]};
        end else if (len >= mrsd_pkg::MOUSE_MIN_LEN && a[1] == mrsd_pkg::REC_TYPE_MOUSE) begin
            r.result_kind = mrsd_pkg::KIND_MOUSE;
            r.button_mask = a[2];
            r.move_x      = $signed(a[3]);
            r.move_y      = $signed(a[4]);
            r.wheel_value = a[5];
            r.action_type = a[6];
            r.delay_ms    = {a[7], a[8]};
        end else begin
            r.result_kind = mrsd_pkg::KIND_UNKNOWN;
            r.mode_or_kind = (len >= 8'd2) ? a[1] : 8'd0;
        end
        return r;
    endfunction

    assign o_stall = i_fifo_status.full;
    assign accept  = i_valid && !i_fifo_status.full;

    always_comb begin
        n_pos   = r_pos;
        n_zero  = r_zero;
        n_ones  = r_ones;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_off   = r_off;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_stop  = r_stop;
        res     = '0;
        has_res = 1'b0;

        if (r_pos < mrsd_pkg::POS_LIMIT) begin
            n_pos = r_pos + 1'b1;
            if (r_pos < mrsd_pkg::POS_PROBE_LEN) begin
                if (i_data_byte != 8'h00) n_zero = 1'b0;
                if (i_data_byte != 8'hff) n_ones = 1'b0;
                if (r_pos == mrsd_pkg::POS_PROBE_LAST && (n_zero || n_ones)) begin
                    res.result_kind = mrsd_pkg::KIND_EMPTY;
                    has_res         = 1'b1;
                end
            end else if (!(r_zero || r_ones) && !r_stop) begin
                if (r_pos == mrsd_pkg::POS_COUNT_HI) begin
                    n_hdr = {i_data_byte, 8'h00};
                end else if (r_pos == mrsd_pkg::POS_COUNT_LO) begin
                    n_hdr = {r_hdr[15:8], i_data_byte};
                end else if (r_pos == mrsd_pkg::POS_MODE) begin
                    res.result_kind  = mrsd_pkg::KIND_HEADER;
                    res.count_value  = r_hdr;
                    res.mode_or_kind = i_data_byte;
                    has_res          = 1'b1;
                end else if (r_pos >= mrsd_pkg::POS_HEADER_END) begin
                    if (r_off == 8'd0) begin
                        if (i_data_byte == 8'd0) begin
                            n_stop = 1'b1;
                        end else begin
                            n_len    = i_data_byte;
                            n_buf[0] = i_data_byte;
                            n_off    = 8'd1;
                            // A one-byte record is complete on its length byte.
                            if (i_data_byte == 8'd1) begin
                                res     = decode_record(n_buf, n_len, r_cnt);
                                has_res = 1'b1;
                                n_cnt   = r_cnt + 10'd1;
                                n_off   = 8'd0;
                            end
                        end
                    end else begin
                        if (r_off < 8'(mrsd_pkg::REC_KEEP))
                            n_buf[r_off[mrsd_pkg::REC_IDX_W-1:0]] = i_data_byte;
                        n_off = r_off + 8'd1;
                        if (n_off == r_len) begin
                            res     = decode_record(n_buf, r_len, r_cnt);
                            has_res = 1'b1;
                            n_cnt   = r_cnt + 10'd1;
                            n_off   = 8'd0;
                        end
                    end
                end
            end
        end

        if (i_end_of_stream) begin
            if (!has_res) begin
                if (n_pos < mrsd_pkg::POS_PROBE_LEN) begin
                    res.result_kind = mrsd_pkg::KIND_NO_DATA;
                    has_res         = 1'b1;
                end else if (n_zero || n_ones) begin
                    has_res = 1'b0;
                end else if (n_pos < mrsd_pkg::POS_HEADER_END) begin
                    res.result_kind = mrsd_pkg::KIND_SHORT_HDR;
                    res.count_value = 16'(n_pos);
                    has_res         = 1'b1;
                end else if (!n_stop && n_off != 8'd0) begin
                    res.result_kind = mrsd_pkg::KIND_TRUNCATED;
                    res.step_number = r_cnt + 10'd1;
                    res.count_value = {8'd0, n_len};
                    has_res         = 1'b1;
                end else begin
                    res.result_kind = mrsd_pkg::KIND_END;
                    has_res         = 1'b1;
                end
            end
            // The next slot starts from a clean state.
            n_pos  = '0;
            n_zero = 1'b1;
            n_ones = 1'b1;
            n_hdr  = '0;
            n_len  = '0;
            n_off  = '0;
            n_cnt  = '0;
            n_stop = 1'b0;
        end
    end

    assign o_push      = accept && has_res;
    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_zero <= 1'b1;
            r_ones <= 1'b1;
            r_hdr  <= '0;
            r_len  <= '0;
            r_off  <= '0;
            r_cnt  <= '0;
            r_stop <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_zero <= n_zero;
            r_ones <= n_ones;
            r_hdr  <= n_hdr;
            r_len  <= n_len;
            r_off  <= n_off;
            r_cnt  <= n_cnt;
            r_stop <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
    end

endmodule

@@ rtl/mrsd_fifo.sv @@
// Short result queue between the front and back parts.
// Depends on mrsd_pkg.
module mrsd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mrsd_pkg::t_result      i_push_data,
    input  logic                   i_pop,
    output mrsd_pkg::t_result      o_pop_data,
    output mrsd_pkg::t_fifo_status o_status
);

    mrsd_pkg::t_result                r_mem [mrsd_pkg::FIFO_DEPTH];
    logic [mrsd_pkg::FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [mrsd_pkg::FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [mrsd_pkg::FIFO_CNT_W-1:0]  r_count;

    localparam logic [mrsd_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        mrsd_pkg::FIFO_PTR_W'(mrsd_pkg::FIFO_DEPTH - 1);
    localparam logic [mrsd_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        mrsd_pkg::FIFO_CNT_W'(mrsd_pkg::FIFO_DEPTH);

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= n_wr_ptr;
            if (i_pop)  r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/mrsd_back.sv @@
// Back part: moves queued results into the output register and serves the stall.
// Depends on mrsd_pkg.
module mrsd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mrsd_pkg::t_fifo_status i_fifo_status,
    input  mrsd_pkg::t_result      i_pop_data,
    output logic                   o_pop,
    input  logic                   i_stall,
    output logic                   o_valid,
    output mrsd_pkg::t_result      o_result
);

    logic              r_valid;
    mrsd_pkg::t_result r_result;

    // Load whenever the register is empty or its content leaves this cycle.
    assign o_pop    = !i_fifo_status.empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_pop_data;
        end
    end

endmodule

@@ rtl/macro_record_stream_decoder.sv @@
// Top level of the macro record stream decoder.
// Depends on mrsd_pkg, mrsd_front, mrsd_fifo and mrsd_back.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------------
//   input   | in        | i_valid / o_stall  | i_data_byte, i_end_of_stream
//   result  | out       | o_valid / i_stall  | o_result_kind ... o_wheel_value
//
// One byte transaction is taken in every cycle while the two-entry result queue has room.
// Each result is queued as its byte is taken and loaded once the output register is free.
// Reset is synchronous and active low; it clears the slot state, the queue and o_valid.
// While i_stall is high the output register holds, the queue fills, and o_stall rises
// once both queue entries are taken, so the input side stops only when results back up.
//
// The front part follows the slot layout: an 8-byte probe for an empty slot, the 35-byte
// header whose last three bytes carry the count and mode, then length-prefixed action
// records. A record is decoded from its first nine bytes in the cycle its last byte
// arrives; longer records simply skip the rest. The end flag closes the slot and, if the
// last byte produced nothing else and the slot is not empty, yields a no data, short
// header, truncated or end result. Each end of stream resets the front's slot state.
module macro_record_stream_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_stream,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_result_kind,
    output logic [9:0]         o_step_number,
    output logic [15:0]        o_count_value,
    output logic [7:0]         o_mode_or_kind,
    output logic [7:0]         o_modifier_mask,
    output logic [7:0]         o_key_code,
    output logic [7:0]         o_action_type,
    output logic [15:0]        o_delay_ms,
    output logic [7:0]         o_button_mask,
    output logic signed [7:0]  o_move_x,
    output logic signed [7:0]  o_move_y,
    output logic [7:0]         o_wheel_value
);

    mrsd_pkg::t_fifo_status fifo_status;
    mrsd_pkg::t_result      push_data;
    mrsd_pkg::t_result      pop_data;
    mrsd_pkg::t_result      result;
    logic                   push;
    logic                   pop;

    // Front part: byte acceptance, slot tracking and record decoding.
    mrsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_fifo_status   (fifo_status),
        .o_push          (push),
        .o_push_data     (push_data)
    );

    // The queue decouples the two sides so a stalled output does not stop input at once.
    mrsd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (fifo_status)
    );

    // Back part: output register toward the result consumer.
    mrsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fifo_status (fifo_status),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result      (result)
    );

    assign o_result_kind   = result.result_kind;
    assign o_step_number   = result.step_number;
    assign o_count_value   = result.count_value;
    assign o_mode_or_kind  = result.mode_or_kind;
    assign o_modifier_mask = result.modifier_mask;
    assign o_key_code      = result.key_code;
    assign o_action_type   = result.action_type;
    assign o_delay_ms      = result.delay_ms;
    assign o_button_mask   = result.button_mask;
    assign o_move_x        = result.move_x;
    assign o_move_y        = result.move_y;
    assign o_wheel_value   = result.wheel_value;

endmodule
